@@ hdl/clcd_pkg.sv @@
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared types and constants for the character LCD controller bus interface.
// ----------------------------------------------------------------------------
package clcd_pkg;

  localparam int ADDR_W    = 7;
  localparam int BYTE_W    = 8;
  localparam int DRAM_DEPTH = 128;
  localparam int GRAM_DEPTH = 64;

  // bus access kinds, carried on tuser
  typedef enum logic [1:0] {
    OP_INSTR_WR  = 2'd0,
    OP_STATUS_RD = 2'd1,
    OP_DATA_WR   = 2'd2,
    OP_DATA_RD   = 2'd3
  } opcode_t;

  // instruction decode, highest set bit wins
  localparam int IR_SET_DDRAM = 7;
  localparam int IR_SET_CGRAM = 6;
  localparam int IR_FUNC_SET  = 5;
  localparam int IR_SHIFT     = 4;
  localparam int IR_ON_OFF    = 3;
  localparam int IR_ENTRY     = 2;
  localparam int IR_HOME      = 1;
  localparam int IR_CLEAR     = 0;

  localparam logic [BYTE_W-1:0] FILL_CHAR  = 8'h20;
  localparam logic [BYTE_W-1:0] GLYPH_RST  = 8'h00;

  localparam logic [ADDR_W-1:0] LINE1_END      = 7'h4f;
  localparam logic [ADDR_W-1:0] LINE2_A_END    = 7'h27;
  localparam logic [ADDR_W-1:0] LINE2_B_START  = 7'h40;
  localparam logic [ADDR_W-1:0] LINE2_B_END    = 7'h67;
  localparam logic [ADDR_W-1:0] SHIFT_MAX      = 7'h4f;

  // wrap rule applied by the step unit
  typedef enum logic [1:0] {
    STEP_GLYPH = 2'd0,
    STEP_LINE1 = 2'd1,
    STEP_LINE2 = 2'd2,
    STEP_SHIFT = 2'd3
  } step_kind_t;

  typedef struct packed {
    logic [ADDR_W-1:0] value;
    logic              down;
    step_kind_t        kind;
  } step_req_t;

endpackage

@@ hdl/clcd_ram.sv @@
// ----------------------------------------------------------------------------
// clcd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module clcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/clcd_step.sv @@
// ----------------------------------------------------------------------------
// clcd_step
// Shared step unit: one +/-1 adder plus the line, glyph and shift wrap rules.
// ----------------------------------------------------------------------------
module clcd_step (
  input  clcd_pkg::step_req_t         req,
  output logic [clcd_pkg::ADDR_W-1:0] result
);
  import clcd_pkg::*;

  logic [ADDR_W-1:0] sum;

  assign sum = req.value + (req.down ? {ADDR_W{1'b1}} : ADDR_W'(1));

  always_comb begin
    result = sum;
    case (req.kind)
      STEP_GLYPH: begin
        result = {1'b0, sum[ADDR_W-2:0]};
      end
      STEP_LINE1: begin
        if (req.down && req.value == '0) result = LINE1_END;
        else if (!req.down && req.value == LINE1_END) result = '0;
      end
      STEP_LINE2: begin
        if (req.down) begin
          if (req.value == '0) result = LINE2_B_END;
          else if (req.value == LINE2_B_START) result = LINE2_A_END;
        end else begin
          if (req.value == LINE2_A_END) result = LINE2_B_START;
          else if (req.value == LINE2_B_END) result = '0;
        end
      end
      STEP_SHIFT: begin
        if (req.down) begin
          if (req.value == '0 || req.value > SHIFT_MAX) result = SHIFT_MAX;
        end else if (req.value >= SHIFT_MAX) begin
          result = '0;
        end
      end
      default: result = sum;
    endcase
  end

endmodule

@@ hdl/char_lcd_controller_bus_interface.sv @@
// ----------------------------------------------------------------------------
// char_lcd_controller_bus_interface
// Bus side of a character LCD controller: instruction/data/status requests
// with 8-bit or paired 4-bit transfers, display and glyph RAM, address
// counter, display shift and mode flags.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                           | tuser
//  --------+-----+----------------------------------------------+-----------
//  s_*     | in  | bus_data[7:0]                                | opcode[1:0]
//  m_*     | out | read_data[7:0], display_enabled, cursor_     | -
//          |     | enabled, blink_enabled, shift_amount[6:0],   |
//          |     | address_now[6:0], 7 zero bits                |
//
//  Every request runs from accept to the next accept through execute,
//  then the address step and the shift step, which use the one shared step
//  unit in turn, then the result load.
//  The result register is loaded in DONE; if it still holds an
//  untaken result, the sequencer waits in DONE until m_tready frees it.
//  A new request is taken in IDLE even while a result waits downstream.
//  Reset (rst, synchronous) is instant: RAM contents are covered by
//  per-entry valid bits, so no fill sweep is needed after reset or clear.
// ----------------------------------------------------------------------------
module char_lcd_controller_bus_interface (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] bus_data
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [7:0] read_data, [8] display_enabled,
                                 // [9] cursor_enabled, [10] blink_enabled,
                                 // [17:11] shift_amount, [24:18] address_now
);
  import clcd_pkg::*;

  // one-hot sequencer
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_ADDR  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  localparam int GAW = $clog2(GRAM_DEPTH);

  state_t state;

  // captured request
  opcode_t           op;
  logic [BYTE_W-1:0] din;

  // controller state
  logic [ADDR_W-1:0] address;
  logic [ADDR_W-1:0] shift_pos;
  logic [BYTE_W-1:0] instr;
  logic [BYTE_W-1:0] data_hold;
  logic              glyph_sel;
  logic              display_flag;
  logic              cursor_flag;
  logic              blink_flag;
  logic              auto_shift;
  logic              decrement;
  logic              four_bit_mode;
  logic              two_line_mode;
  logic              tall_font;
  logic              nibble_phase;
  logic              first_command;
  logic              last_rs;
  logic              last_rw;

  // pending step work and read result
  logic              step_addr;
  logic              step_shift;
  logic              step_down;
  logic [BYTE_W-1:0] rd_val;
  logic              step_addr_next;
  logic              step_shift_next;
  logic              step_down_next;
  logic [BYTE_W-1:0] rd_val_next;

  // RAM valid bits: an entry not yet written since reset (display RAM: or clear) reads as fill
  logic [DRAM_DEPTH-1:0] dram_valid;
  logic [GRAM_DEPTH-1:0] gram_valid;
  logic [BYTE_W-1:0]     dram_rdata;
  logic [BYTE_W-1:0]     gram_rdata;
  logic                  dram_we;
  logic                  gram_we;

  // execute-stage decode
  logic              rs;
  logic              rw;
  logic              phase_new;
  logic              first_half;
  logic [BYTE_W-1:0] ir_full;
  logic [BYTE_W-1:0] data_full;
  logic [BYTE_W-1:0] ram_val;
  logic              fs_reject;

  step_req_t         step_req;
  logic [ADDR_W-1:0] step_result;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    rs         = op[1];
    rw         = op[0];
    // a change of access kind restarts the pair, then the phase toggles
    phase_new  = ((last_rs != rs) || (last_rw != rw)) ? 1'b1 : !nibble_phase;
    first_half = four_bit_mode && phase_new;
    ir_full    = four_bit_mode ? (instr | {4'b0, din[7:4]}) : din;
    data_full  = four_bit_mode ? (data_hold | {4'b0, din[7:4]}) : din;
    if (glyph_sel) begin
      ram_val = gram_valid[address[GAW-1:0]] ? gram_rdata : GLYPH_RST;
    end else begin
      ram_val = dram_valid[address] ? dram_rdata : FILL_CHAR;
    end
    // same interface width but new font or line count: ignored
    fs_reject  = !first_command && (ir_full[4] == !four_bit_mode) &&
                 ((ir_full[2] != tall_font) || (ir_full[3] != two_line_mode));
  end

  // step work and read result decided by the execute stage
  always_comb begin
    step_addr_next  = 1'b0;
    step_shift_next = 1'b0;
    step_down_next  = decrement;
    rd_val_next     = '0;
    case (op)
      OP_INSTR_WR: begin
        if (!first_half && !ir_full[IR_SET_DDRAM] && !ir_full[IR_SET_CGRAM] &&
            !ir_full[IR_FUNC_SET] && ir_full[IR_SHIFT]) begin
          step_down_next  = !ir_full[2];
          step_shift_next = ir_full[3];
          step_addr_next  = !ir_full[3];
        end
      end
      OP_STATUS_RD: begin
        // busy bit is always clear
        if (!four_bit_mode) rd_val_next = {1'b0, address};
        else if (phase_new) rd_val_next = {1'b0, address[6:4], 4'b0};
        else rd_val_next = {address[3:0], 4'b0};
      end
      OP_DATA_WR: begin
        if (!first_half) begin
          step_addr_next  = 1'b1;
          step_shift_next = auto_shift;
        end
      end
      OP_DATA_RD: begin
        if (first_half) begin
          rd_val_next = {ram_val[7:4], 4'b0};
        end else begin
          rd_val_next    = four_bit_mode ? {ram_val[3:0], 4'b0} : ram_val;
          step_addr_next = 1'b1;
        end
      end
      default: rd_val_next = '0;
    endcase
  end

  assign dram_we = (state == S_EXEC) && (op == OP_DATA_WR) && !first_half && !glyph_sel;
  assign gram_we = (state == S_EXEC) && (op == OP_DATA_WR) && !first_half && glyph_sel;

  clcd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DRAM_DEPTH)
  ) u_dram (
    .clk   (clk),
    .we    (dram_we),
    .waddr (address),
    .wdata (data_full),
    .raddr (address),
    .rdata (dram_rdata)
  );

  clcd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (GRAM_DEPTH)
  ) u_gram (
    .clk   (clk),
    .we    (gram_we),
    .waddr (address[GAW-1:0]),
    .wdata (data_full),
    .raddr (address[GAW-1:0]),
    .rdata (gram_rdata)
  );

  // step unit shared between the address and shift steps
  always_comb begin
    step_req.down = step_down;
    if (state == S_SHIFT) begin
      step_req.value = shift_pos;
      step_req.kind  = STEP_SHIFT;
    end else begin
      step_req.value = address;
      if (glyph_sel) step_req.kind = STEP_GLYPH;
      else if (two_line_mode) step_req.kind = STEP_LINE2;
      else step_req.kind = STEP_LINE1;
    end
  end

  clcd_step u_step (
    .req    (step_req),
    .result (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      address       <= '0;
      shift_pos     <= '0;
      instr         <= '0;
      data_hold     <= '0;
      glyph_sel     <= 1'b0;
      display_flag  <= 1'b0;
      cursor_flag   <= 1'b0;
      blink_flag    <= 1'b0;
      auto_shift    <= 1'b0;
      decrement     <= 1'b0;
      four_bit_mode <= 1'b0;
      two_line_mode <= 1'b0;
      tall_font     <= 1'b0;
      nibble_phase  <= 1'b0;
      first_command <= 1'b1;
      last_rs       <= 1'b0;
      last_rw       <= 1'b0;
      step_addr     <= 1'b0;
      step_shift    <= 1'b0;
      step_down     <= 1'b0;
      dram_valid    <= '0;
      gram_valid    <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      // result register: load in DONE when free, drop once taken
      if ((state == S_DONE) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op    <= opcode_t'(s_tuser);
            din   <= s_tdata;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          step_addr  <= step_addr_next;
          step_shift <= step_shift_next;
          step_down  <= step_down_next;
          rd_val     <= rd_val_next;
          if (four_bit_mode) begin
            last_rs      <= rs;
            last_rw      <= rw;
            nibble_phase <= phase_new;
          end
          case (op)
            OP_INSTR_WR: begin
              if (first_half) begin
                instr <= {din[7:4], 4'b0};
              end else begin
                instr <= ir_full;
                if (!ir_full[IR_FUNC_SET] || ir_full[IR_SET_DDRAM] ||
                    ir_full[IR_SET_CGRAM]) begin
                  first_command <= 1'b0;
                end
                if (ir_full[IR_SET_DDRAM]) begin
                  glyph_sel <= 1'b0;
                  address   <= ir_full[ADDR_W-1:0];
                end else if (ir_full[IR_SET_CGRAM]) begin
                  glyph_sel <= 1'b1;
                  address   <= {1'b0, ir_full[GAW-1:0]};
                end else if (ir_full[IR_FUNC_SET]) begin
                  if (!fs_reject) begin
                    tall_font     <= ir_full[2];
                    four_bit_mode <= !ir_full[4];
                    two_line_mode <= ir_full[3];
                  end
                end else if (ir_full[IR_SHIFT]) begin
                  // step work comes from the decode above
                end else if (ir_full[IR_ON_OFF]) begin
                  display_flag <= ir_full[2];
                  cursor_flag  <= ir_full[1];
                  blink_flag   <= ir_full[0];
                end else if (ir_full[IR_ENTRY]) begin
                  decrement  <= !ir_full[1];
                  auto_shift <= ir_full[0];
                end else if (ir_full[IR_HOME] || ir_full[IR_CLEAR]) begin
                  address   <= '0;
                  glyph_sel <= 1'b0;
                  decrement <= 1'b0;
                  shift_pos <= '0;
                  if (!ir_full[IR_HOME]) begin
                    dram_valid <= '0;
                  end
                end
              end
            end
            OP_DATA_WR: begin
              if (first_half) begin
                data_hold <= {din[7:4], 4'b0};
              end else begin
                data_hold <= data_full;
                if (glyph_sel) gram_valid[address[GAW-1:0]] <= 1'b1;
                else dram_valid[address] <= 1'b1;
              end
            end
            default: begin
              // reads only return data and step through the decode above
            end
          endcase
          state <= S_ADDR;
        end
        S_ADDR: begin
          if (step_addr) address <= step_result;
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          if (step_shift) shift_pos <= step_result;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {7'b0, address, shift_pos, blink_flag, cursor_flag,
                         display_flag, rd_val};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    shift_pos <= SHIFT_MAX)
    else $error("display shift out of range");

  a_glyph_addr: assert property (@(posedge clk) disable iff (rst)
    glyph_sel |-> !address[ADDR_W-1])
    else $error("glyph address beyond glyph RAM");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while another is in flight");

  a_phase_8bit: assert property (@(posedge clk) disable iff (rst)
    !four_bit_mode |=> $stable(nibble_phase))
    else $error("nibble phase moved in eight-bit mode");
`endif

endmodule

@@ verif/char_lcd_controller_bus_interface_checker.sv @@
// ----------------------------------------------------------------------------
// char_lcd_controller_bus_interface_checker
// Watches both stream channels of the LCD bus interface, predicts the result
// of every accepted request and compares each returned result field by field.
// ----------------------------------------------------------------------------
module char_lcd_controller_bus_interface_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] bus_data
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // [7:0] read_data, [8] display_enabled,
                                 // [9] cursor_enabled, [10] blink_enabled,
                                 // [17:11] shift_amount, [24:18] address_now
  output int          pending,
  output int          fail_count,
  output int          checked
);
  import clcd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // same bit order as m_tdata, read_data lowest
  typedef struct packed {
    logic [ADDR_W-1:0] address_now;
    logic [ADDR_W-1:0] shift_amount;
    logic              blink_enabled;
    logic              cursor_enabled;
    logic              display_enabled;
    logic [BYTE_W-1:0] read_data;
  } lcd_view_t;

  localparam int VIEW_W = $bits(lcd_view_t);
  localparam logic [ADDR_W-1:0] GLYPH_MASK = ADDR_W'(GRAM_DEPTH - 1);

  // predicted controller state
  logic [BYTE_W-1:0] dram [DRAM_DEPTH];
  logic [BYTE_W-1:0] gram [GRAM_DEPTH];
  logic [ADDR_W-1:0] ac;
  logic [ADDR_W-1:0] shift_pos;
  logic [BYTE_W-1:0] ir_hold;
  logic [BYTE_W-1:0] dr_hold;
  bit                cg_sel, disp_on, cur_on, blink_on, auto_shift, dec_mode;
  bit                nib4, two_line, font_tall, half_phase, first_cmd;
  opcode_t           last_kind;

  lcd_view_t         bus_view_q[$];
  lcd_view_t         want, got;
  int                fail_total = 0;
  int                checked_total = 0;

  function automatic void model_reset();
    for (int i = 0; i < DRAM_DEPTH; i++) dram[i] = FILL_CHAR;
    for (int i = 0; i < GRAM_DEPTH; i++) gram[i] = GLYPH_RST;
    ac         = '0;
    shift_pos  = '0;
    ir_hold    = '0;
    dr_hold    = '0;
    cg_sel     = 1'b0;
    disp_on    = 1'b0;
    cur_on     = 1'b0;
    blink_on   = 1'b0;
    auto_shift = 1'b0;
    dec_mode   = 1'b0;
    nib4       = 1'b0;
    two_line   = 1'b0;
    font_tall  = 1'b0;
    half_phase = 1'b0;
    first_cmd  = 1'b1;
    last_kind  = OP_INSTR_WR;
  endfunction

  // returns 1 on the upper half of a nibble pair
  function automatic bit toggle_half(opcode_t kind);
    if (kind != last_kind) begin
      last_kind  = kind;
      half_phase = 1'b0;
    end
    half_phase = !half_phase;
    return half_phase;
  endfunction

  function automatic void step_ac(bit down);
    if (cg_sel) begin
      ac = down ? ((ac - 1'b1) & GLYPH_MASK) : ((ac + 1'b1) & GLYPH_MASK);
      return;
    end
    if (!down) begin
      if (two_line && ac == LINE2_A_END) ac = LINE2_B_START;
      else if ((two_line && ac == LINE2_B_END) || (!two_line && ac == LINE1_END)) ac = '0;
      else ac = ac + 1'b1;
    end else begin
      if (ac == '0) ac = two_line ? LINE2_B_END : LINE1_END;
      else if (two_line && ac == LINE2_B_START) ac = LINE2_A_END;
      else ac = ac - 1'b1;
    end
  endfunction

  function automatic void step_shift(bit down);
    if (!down) shift_pos = (shift_pos >= SHIFT_MAX) ? '0 : shift_pos + 1'b1;
    else shift_pos = (shift_pos == '0 || shift_pos > SHIFT_MAX) ? SHIFT_MAX : shift_pos - 1'b1;
  endfunction

  function automatic void go_home();
    ac        = '0;
    cg_sel    = 1'b0;
    dec_mode  = 1'b0;
    shift_pos = '0;
  endfunction

  function automatic void decode_instruction(logic [BYTE_W-1:0] ir);
    bit eight;
    bit two;
    bit tall;
    eight = ir[4];
    two   = ir[3];
    tall  = ir[2];
    if (ir[IR_SET_DDRAM]) begin
      cg_sel = 1'b0;
      ac     = ir[ADDR_W-1:0];
    end else if (ir[IR_SET_CGRAM]) begin
      cg_sel = 1'b1;
      ac     = ir[ADDR_W-1:0] & GLYPH_MASK;
    end else if (ir[IR_FUNC_SET]) begin
      // same width with a new font or line count is refused once running;
      // a function set never counts as the first command
      if (first_cmd || eight != !nib4 || (tall == font_tall && two == two_line)) begin
        font_tall = tall;
        nib4      = !eight;
        two_line  = two;
      end
      return;
    end else if (ir[IR_SHIFT]) begin
      if (ir[3]) step_shift(!ir[2]);
      else step_ac(!ir[2]);
    end else if (ir[IR_ON_OFF]) begin
      disp_on  = ir[2];
      cur_on   = ir[1];
      blink_on = ir[0];
    end else if (ir[IR_ENTRY]) begin
      dec_mode   = !ir[1];
      auto_shift = ir[0];
    end else if (ir[IR_HOME]) begin
      go_home();
    end else if (ir[IR_CLEAR]) begin
      go_home();
      for (int i = 0; i < DRAM_DEPTH; i++) dram[i] = FILL_CHAR;
    end
    first_cmd = 1'b0;
  endfunction

  // applies one bus request to the predicted state, returns the bus view
  function automatic lcd_view_t lcd_access(opcode_t op, logic [BYTE_W-1:0] d);
    lcd_view_t         v;
    logic [BYTE_W-1:0] ram_byte;
    bit                commit;
    v      = '0;
    commit = 1'b1;
    case (op)
      OP_INSTR_WR: begin
        if (!nib4) begin
          ir_hold = d;
          decode_instruction(ir_hold);
        end else if (toggle_half(OP_INSTR_WR)) begin
          ir_hold = {d[7:4], 4'h0};
        end else begin
          ir_hold = ir_hold | (d >> 4);
          decode_instruction(ir_hold);
        end
      end
      OP_STATUS_RD: begin
        if (!nib4) v.read_data = {1'b0, ac};
        else if (toggle_half(OP_STATUS_RD)) v.read_data = {1'b0, ac[6:4], 4'h0};
        else v.read_data = {ac[3:0], 4'h0};
      end
      OP_DATA_WR: begin
        if (nib4) begin
          if (toggle_half(OP_DATA_WR)) begin
            dr_hold = {d[7:4], 4'h0};
            commit  = 1'b0;
          end else begin
            dr_hold = dr_hold | (d >> 4);
          end
        end else begin
          dr_hold = d;
        end
        if (commit) begin
          if (cg_sel) gram[ac[5:0]] = dr_hold;
          else dram[ac] = dr_hold;
          step_ac(dec_mode);
          if (auto_shift) step_shift(dec_mode);
        end
      end
      OP_DATA_RD: begin
        ram_byte = cg_sel ? gram[ac[5:0]] : dram[ac];
        if (nib4) begin
          if (toggle_half(OP_DATA_RD)) begin
            ram_byte = {ram_byte[7:4], 4'h0};
            commit   = 1'b0;
          end else begin
            ram_byte = {ram_byte[3:0], 4'h0};
          end
        end
        if (commit) step_ac(dec_mode);
        v.read_data = ram_byte;
      end
    endcase
    v.display_enabled = disp_on;
    v.cursor_enabled  = cur_on;
    v.blink_enabled   = blink_on;
    v.shift_amount    = shift_pos;
    v.address_now     = ac;
    return v;
  endfunction

  task automatic check_field(string name, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      fail_total++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      model_reset();
      bus_view_q.delete();
    end else begin
      if (s_tvalid && s_tready)
        bus_view_q.push_back(lcd_access(opcode_t'(s_tuser), s_tdata));
      if (m_tvalid && m_tready) begin
        if (bus_view_q.size() == 0) begin
          $error("result with no request outstanding: tdata 0x%08h", m_tdata);
          fail_total++;
        end else begin
          want = bus_view_q.pop_front();
          got  = lcd_view_t'(m_tdata[VIEW_W-1:0]);
          check_field("read_data", want.read_data, got.read_data);
          check_field("display_enabled", want.display_enabled, got.display_enabled);
          check_field("cursor_enabled", want.cursor_enabled, got.cursor_enabled);
          check_field("blink_enabled", want.blink_enabled, got.blink_enabled);
          check_field("shift_amount", want.shift_amount, got.shift_amount);
          check_field("address_now", want.address_now, got.address_now);
          check_field("tdata padding", 0, 32'(m_tdata[31:VIEW_W]));
          checked_total++;
        end
      end
    end
    pending    <= bus_view_q.size();
    fail_count <= fail_total;
    checked    <= checked_total;
  end

endmodule

@@ verif/char_lcd_controller_bus_interface_tb.sv @@
// ----------------------------------------------------------------------------
// char_lcd_controller_bus_interface_tb
// Drives bus requests into the LCD controller bus interface: a directed pass
// over the instruction set, wrap points and nibble mode, then random traffic
// built mostly from well-paired 4-bit and plain 8-bit accesses with some
// stray nibbles. Both stream sides idle at random; a separate checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module char_lcd_controller_bus_interface_tb;
  import clcd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS   = 1150;
  // idle cycles with no handshake on either side; a correct run stays far
  // below this (longest sender gap plus longest sink stall plus one request)
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 20;

  // instruction encodings, built from the decode bit positions
  localparam logic [7:0] CMD_NOP    = 8'h00;
  localparam logic [7:0] CMD_CLEAR  = 8'h01 << IR_CLEAR;
  localparam logic [7:0] CMD_HOME   = 8'h01 << IR_HOME;
  localparam logic [7:0] CMD_ENTRY  = 8'h01 << IR_ENTRY;
  localparam logic [7:0] CMD_ON_OFF = 8'h01 << IR_ON_OFF;
  localparam logic [7:0] CMD_SHIFT  = 8'h01 << IR_SHIFT;
  localparam logic [7:0] CMD_FUNC   = 8'h01 << IR_FUNC_SET;
  localparam logic [7:0] CMD_CGRAM  = 8'h01 << IR_SET_CGRAM;
  localparam logic [7:0] CMD_DDRAM  = 8'h01 << IR_SET_DDRAM;
  // option bits inside those instructions
  localparam logic [7:0] FN_8BIT     = 8'h10;
  localparam logic [7:0] FN_2LINE    = 8'h08;
  localparam logic [7:0] FN_TALL     = 8'h04;
  localparam logic [7:0] ON_DISPLAY  = 8'h04;
  localparam logic [7:0] ON_CURSOR   = 8'h02;
  localparam logic [7:0] ON_BLINK    = 8'h01;
  localparam logic [7:0] ENTRY_INC   = 8'h02;
  localparam logic [7:0] ENTRY_SHIFT = 8'h01;
  localparam logic [7:0] SH_DISPLAY  = 8'h08;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;   // [7:0] bus_data
  logic [1:0]  s_tuser  = '0;   // [1:0] opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // [7:0] read_data, [8] display_enabled,
                                // [9] cursor_enabled, [10] blink_enabled,
                                // [17:11] shift_amount, [24:18] address_now

  int pending;
  int errors;
  int checked;

  // Stimulus-side view of the transfer width and nibble pairing, so that
  // pairs can be kept aligned. Only width and pairing are followed here.
  bit         mode_4bit      = 1'b0;
  bit         half_open      = 1'b0;
  opcode_t    last_kind_sent = OP_INSTR_WR;
  logic [7:0] upper_ir       = '0;

  bit tx_calm = 1'b0;   // sender stretch with no gaps
  bit rx_calm = 1'b0;   // sink stretch with no stalls

  int n_sent      = 0;
  int n_nibble    = 0;
  int n_width_sw  = 0;
  int n_drains    = 0;
  int n_by_op[4]  = '{default: 0};
  int idle_cycles = 0;

  always #5 clk = ~clk;

  char_lcd_controller_bus_interface u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  char_lcd_controller_bus_interface_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .pending    (pending),
    .fail_count (errors),
    .checked    (checked)
  );

  // Gap length: mostly none or short, now and then long; zero while calm.
  function automatic int pause_len(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // One request: optional gap, then hold valid until the handshake.
  // Valid is lowered only for a real gap, so back-to-back requests never
  // see a low and a high scheduled in the same step.
  task automatic send_req(opcode_t op, logic [7:0] d);
    int         gap;
    logic [7:0] full_ir;
    bit         ir_done;
    gap = pause_len(tx_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);

    n_sent++;
    n_by_op[op]++;
    ir_done = 1'b0;
    full_ir = '0;
    if (mode_4bit) begin
      n_nibble++;
      // a change of request kind restarts the pairing
      if (op != last_kind_sent) begin
        last_kind_sent = op;
        half_open      = 1'b0;
      end
      half_open = !half_open;
      if (op == OP_INSTR_WR) begin
        if (half_open) begin
          upper_ir = {d[7:4], 4'h0};
        end else begin
          full_ir = upper_ir | (d >> 4);
          ir_done = 1'b1;
        end
      end
    end else if (op == OP_INSTR_WR) begin
      full_ir = d;
      ir_done = 1'b1;
    end
    // a function set that changes the width is always taken
    if (ir_done && !full_ir[IR_SET_DDRAM] && !full_ir[IR_SET_CGRAM] &&
        full_ir[IR_FUNC_SET] && full_ir[4] == mode_4bit) begin
      mode_4bit = !mode_4bit;
      n_width_sw++;
    end
  endtask

  // Full byte as one request, or as an aligned upper/lower nibble pair.
  // If a pair of the same kind is half open, a different read closes the
  // pairing first. Low nibbles of the pair carry random filler.
  task automatic issue_access(opcode_t op, logic [7:0] d);
    if (!mode_4bit) begin
      send_req(op, d);
    end else begin
      if (half_open && last_kind_sent == op)
        send_req((op == OP_STATUS_RD) ? OP_DATA_RD : OP_STATUS_RD, 8'($urandom_range(0, 255)));
      send_req(op, {d[7:4], 4'($urandom_range(0, 15))});
      send_req(op, {d[3:0], 4'($urandom_range(0, 15))});
    end
  endtask

  // Sender holds off until every outstanding result has come back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    n_drains++;
  endtask

  // Random instruction, weighted toward address and shift traffic. Address
  // sets favor the line wrap points. Function sets mostly keep the width
  // (exercising the refusal rule) and sometimes switch it.
  function automatic logic [7:0] pick_instruction();
    int               k;
    logic [ADDR_W-1:0] a;
    k = $urandom_range(0, 99);
    if (k < 20) begin
      case ($urandom_range(0, 11))
        0:       a = '0;
        1:       a = LINE2_A_END;
        2:       a = LINE2_B_START;
        3:       a = LINE1_END;
        4:       a = LINE2_B_END;
        5:       a = '1;
        default: a = ADDR_W'($urandom_range(0, DRAM_DEPTH - 1));
      endcase
      return CMD_DDRAM | {1'b0, a};
    end
    if (k < 30) return CMD_CGRAM | 8'($urandom_range(0, GRAM_DEPTH - 1));
    if (k < 40) begin
      if ($urandom_range(0, 99) < 15)
        return CMD_FUNC | (mode_4bit ? FN_8BIT : 8'h00) | 8'($urandom_range(0, 15));
      return CMD_FUNC | (mode_4bit ? 8'h00 : FN_8BIT) | 8'($urandom_range(0, 15));
    end
    if (k < 60) return CMD_SHIFT  | 8'($urandom_range(0, 15));
    if (k < 72) return CMD_ON_OFF | 8'($urandom_range(0, 7));
    if (k < 85) return CMD_ENTRY  | 8'($urandom_range(0, 3));
    if (k < 93) return CMD_HOME   | 8'($urandom_range(0, 1));
    if (k < 97) return CMD_CLEAR;
    return CMD_NOP;
  endfunction

  // Sink side: runs of ready broken by random stalls, with calm stretches.
  initial begin
    int run_len;
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
      m_tready <= 1'b1;
      run_len = $urandom_range(1, 8);
      repeat (run_len) @(posedge clk);
      stall = pause_len(rx_calm);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Watchdog: too long without any handshake ends the run.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int n_directed;
    int r;
    bit drained;
    drained = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    // reset state: status reads 0, display RAM reads the fill character
    send_req(OP_STATUS_RD, 8'h00);
    send_req(OP_DATA_RD, 8'hff);
    send_req(OP_DATA_WR, 8'hff);
    // function sets before the first real command are all taken
    issue_access(OP_INSTR_WR, CMD_FUNC | FN_8BIT | FN_2LINE | FN_TALL);
    issue_access(OP_INSTR_WR, CMD_FUNC | FN_8BIT);
    issue_access(OP_INSTR_WR, CMD_ON_OFF | ON_DISPLAY | ON_CURSOR | ON_BLINK);
    // same width, new line count: refused now
    issue_access(OP_INSTR_WR, CMD_FUNC | FN_8BIT | FN_2LINE);
    issue_access(OP_INSTR_WR, CMD_NOP);
    // auto shift on, write at the end of the single line -> wraps to 0
    issue_access(OP_INSTR_WR, CMD_ENTRY | ENTRY_INC | ENTRY_SHIFT);
    issue_access(OP_INSTR_WR, CMD_DDRAM | {1'b0, LINE1_END});
    send_req(OP_DATA_WR, 8'h00);
    // display shift left twice: 1 -> 0 -> wrap to the top
    issue_access(OP_INSTR_WR, CMD_SHIFT | SH_DISPLAY);
    issue_access(OP_INSTR_WR, CMD_SHIFT | SH_DISPLAY);
    // last glyph entry, write wraps the glyph address
    issue_access(OP_INSTR_WR, CMD_CGRAM | 8'(GRAM_DEPTH - 1));
    send_req(OP_DATA_WR, 8'h5a);
    issue_access(OP_INSTR_WR, CMD_CLEAR);
    // switch to 4-bit, two lines; then paired accesses across the line gap
    issue_access(OP_INSTR_WR, CMD_FUNC | FN_2LINE);
    issue_access(OP_INSTR_WR, CMD_DDRAM | {1'b0, LINE2_A_END});
    issue_access(OP_DATA_WR, 8'hc3);
    issue_access(OP_STATUS_RD, 8'h0f);
    issue_access(OP_DATA_RD, 8'hf0);
    n_directed = n_sent;

    // ---- random part ----
    while (n_sent < n_directed + RANDOM_ITEMS) begin
      if ($urandom_range(0, 79) == 0) tx_calm = !tx_calm;
      // let the pipe run dry at least once mid-run, then now and then
      if ((!drained && n_sent >= n_directed + RANDOM_ITEMS / 2) ||
          $urandom_range(0, 299) == 0) begin
        drain_results();
        drained = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 8) send_req(opcode_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      else if (r < 40) issue_access(OP_INSTR_WR, pick_instruction());
      else if (r < 65) issue_access(OP_DATA_WR, 8'($urandom_range(0, 255)));
      else if (r < 85) issue_access(OP_DATA_RD, 8'($urandom_range(0, 255)));
      else issue_access(OP_STATUS_RD, 8'($urandom_range(0, 255)));
    end

    // all requests accepted; wait for the last results, then a short tail
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Coverage: %0d requests (%0d instr, %0d status, %0d data wr, %0d data rd), %0d as nibbles",
             n_sent, n_by_op[OP_INSTR_WR], n_by_op[OP_STATUS_RD], n_by_op[OP_DATA_WR],
             n_by_op[OP_DATA_RD], n_nibble);
    $display("Coverage: %0d results compared, %0d width switches, %0d full drains",
             checked, n_width_sw, n_drains);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
